// ===== rtl/hjbd_pkg.sv =====
// Shared constants, types and helpers for the headset jack and button detector.
package hjbd_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int TIMER_BITS  = 16;
    localparam int ADC_BITS    = 10;

    localparam int QAW       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW       = $clog2(QUEUE_DEPTH + 1);
    localparam int DLY_BITS  = 16;
    localparam int THR_BITS  = 10;
    localparam int CMP_BITS  = (ADC_BITS > THR_BITS) ? ADC_BITS : THR_BITS;
    localparam int KIND_BITS = 3;
    localparam int APB_AW    = 5;
    localparam int APB_DW    = 32;

    localparam logic [32:0] TIMER_MAX = (33'd1 << TIMER_BITS) - 33'd1;

    localparam logic                RST_POLARITY     = 1'b0;
    localparam logic [DLY_BITS-1:0] RST_INSERT_DLY   = 16'd1000;
    localparam logic [DLY_BITS-1:0] RST_RELEASE_TO   = 16'd50;
    localparam logic [DLY_BITS-1:0] RST_DISPATCH_DLY = 16'd500;
    localparam logic [DLY_BITS-1:0] RST_AMP_DLY      = 16'd40;
    localparam logic [THR_BITS-1:0] RST_MIC_THR      = 10'h100;

    typedef enum logic [2:0] {
        REG_POLARITY     = 3'd0,
        REG_INSERT_DLY   = 3'd1,
        REG_RELEASE_TO   = 3'd2,
        REG_DISPATCH_DLY = 3'd3,
        REG_AMP_DLY      = 3'd4,
        REG_MIC_THR      = 3'd5
    } t_reg_idx;

    typedef enum logic [KIND_BITS-1:0] {
        EV_STATUS = 3'd0,
        EV_INSERT = 3'd1,
        EV_REMOVE = 3'd2,
        EV_KDOWN  = 3'd3,
        EV_KUP    = 3'd4
    } t_ev_kind;

    typedef enum logic [1:0] {
        SRC_KUP  = 2'd0,
        SRC_JACK = 2'd1,
        SRC_DISP = 2'd2,
        SRC_STAT = 2'd3
    } t_emit_src;

    typedef struct packed {
        logic                polarity;
        logic [DLY_BITS-1:0] insert_dly;
        logic [DLY_BITS-1:0] release_to;
        logic [DLY_BITS-1:0] dispatch_dly;
        logic [DLY_BITS-1:0] amp_dly;
        logic [THR_BITS-1:0] mic_thr;
    } t_cfg;

    typedef struct packed {
        logic      load_in;
        logic      eval;
        logic      wr_dn;
        logic      wr_up;
        logic      idx_adv;
        logic      emit;
        t_emit_src emit_src;
    } t_cmd;

    typedef struct packed {
        logic ev_kup;
        logic ev_jack;
        logic disp_any;
        logic disp_last;
        logic out_free;
    } t_sts;

    function automatic logic [TIMER_BITS-1:0] load_delay(input logic [DLY_BITS-1:0] v);
        logic [32:0] w;
        w = {{(33-DLY_BITS){1'b0}}, v};
        if (w == 33'd0) begin
            w = 33'd1;
        end
        if (w > TIMER_MAX) begin
            w = TIMER_MAX;
        end
        return w[TIMER_BITS-1:0];
    endfunction

endpackage

// ===== rtl/hjbd_if.sv =====
// Valid/ready channel interfaces for tick items and detector events.
interface hjbd_in_if;
    import hjbd_pkg::*;
    logic                valid;
    logic                ready;
    logic                plug_level;
    logic                button_level;
    logic                codec_on;
    logic [ADC_BITS-1:0] mic_level;

    modport source (output valid, plug_level, button_level, codec_on, mic_level, input ready);
    modport sink   (input valid, plug_level, button_level, codec_on, mic_level, output ready);
endinterface

interface hjbd_out_if;
    import hjbd_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [KIND_BITS-1:0] event_kind;
    logic                 mic_flag;
    logic                 amp_enable;
    logic                 jack_inserted;
    logic                 mic_detected;
    logic                 queue_dropped;
    logic                 last;

    modport source (output valid, event_kind, mic_flag, amp_enable, jack_inserted,
                    mic_detected, queue_dropped, last, input ready);
    modport sink   (input valid, event_kind, mic_flag, amp_enable, jack_inserted,
                    mic_detected, queue_dropped, last, output ready);
endinterface

// ===== rtl/hjbd_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module hjbd_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/hjbd_regs.sv =====
// APB-style configuration register bank.
module hjbd_regs (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [hjbd_pkg::APB_AW-1:0] paddr,
    input  logic [hjbd_pkg::APB_DW-1:0] pwdata,
    output logic [hjbd_pkg::APB_DW-1:0] prdata,
    output logic                     pready,
    output hjbd_pkg::t_cfg           o_cfg
);
    import hjbd_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx idx;
    logic     wr;

    assign idx    = t_reg_idx'(paddr[4:2]);
    assign wr     = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.polarity     <= RST_POLARITY;
            r_cfg.insert_dly   <= RST_INSERT_DLY;
            r_cfg.release_to   <= RST_RELEASE_TO;
            r_cfg.dispatch_dly <= RST_DISPATCH_DLY;
            r_cfg.amp_dly      <= RST_AMP_DLY;
            r_cfg.mic_thr      <= RST_MIC_THR;
        end else if (wr) begin
            case (idx)
                REG_POLARITY:     r_cfg.polarity     <= pwdata[0];
                REG_INSERT_DLY:   r_cfg.insert_dly   <= pwdata[DLY_BITS-1:0];
                REG_RELEASE_TO:   r_cfg.release_to   <= pwdata[DLY_BITS-1:0];
                REG_DISPATCH_DLY: r_cfg.dispatch_dly <= pwdata[DLY_BITS-1:0];
                REG_AMP_DLY:      r_cfg.amp_dly      <= pwdata[DLY_BITS-1:0];
                REG_MIC_THR:      r_cfg.mic_thr      <= pwdata[THR_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_POLARITY:     prdata = {{(APB_DW-1){1'b0}}, r_cfg.polarity};
            REG_INSERT_DLY:   prdata = {{(APB_DW-DLY_BITS){1'b0}}, r_cfg.insert_dly};
            REG_RELEASE_TO:   prdata = {{(APB_DW-DLY_BITS){1'b0}}, r_cfg.release_to};
            REG_DISPATCH_DLY: prdata = {{(APB_DW-DLY_BITS){1'b0}}, r_cfg.dispatch_dly};
            REG_AMP_DLY:      prdata = {{(APB_DW-DLY_BITS){1'b0}}, r_cfg.amp_dly};
            REG_MIC_THR:      prdata = {{(APB_DW-THR_BITS){1'b0}}, r_cfg.mic_thr};
            default:          prdata = '0;
        endcase
    end
endmodule

// ===== rtl/hjbd_ctrl.sv =====
// Tick sequencer: accept, evaluate, queue writes, then event emission.
module hjbd_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  hjbd_pkg::t_sts i_sts,
    output hjbd_pkg::t_cmd o_cmd
);
    import hjbd_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EVAL,
        ST_WR_DN,
        ST_WR_UP,
        ST_DPRE,
        ST_KUP,
        ST_JACK,
        ST_DISP,
        ST_STAT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = ST_EVAL;
                end
            end
            ST_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = ST_WR_DN;
            end
            ST_WR_DN: begin
                o_cmd.wr_dn = 1'b1;
                n_state     = ST_WR_UP;
            end
            ST_WR_UP: begin
                o_cmd.wr_up = 1'b1;
                n_state     = ST_DPRE;
            end
            ST_DPRE: begin
                if (i_sts.ev_kup) begin
                    n_state = ST_KUP;
                end else if (i_sts.ev_jack) begin
                    n_state = ST_JACK;
                end else if (i_sts.disp_any) begin
                    n_state = ST_DISP;
                end else begin
                    n_state = ST_STAT;
                end
            end
            ST_KUP: begin
                if (i_sts.out_free) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.emit_src = SRC_KUP;
                    if (i_sts.ev_jack) begin
                        n_state = ST_JACK;
                    end else if (i_sts.disp_any) begin
                        n_state = ST_DISP;
                    end else begin
                        n_state = ST_STAT;
                    end
                end
            end
            ST_JACK: begin
                if (i_sts.out_free) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.emit_src = SRC_JACK;
                    n_state        = i_sts.disp_any ? ST_DISP : ST_STAT;
                end
            end
            ST_DISP: begin
                if (i_sts.out_free) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.emit_src = SRC_DISP;
                    o_cmd.idx_adv  = 1'b1;
                    if (i_sts.disp_last) begin
                        n_state = ST_STAT;
                    end
                end
            end
            ST_STAT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.emit_src = SRC_STAT;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

// ===== rtl/hjbd_dp.sv =====
// Detector datapath: tick state, timers, key event queue and output register.
module hjbd_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  hjbd_pkg::t_cfg                 i_cfg,
    input  hjbd_pkg::t_cmd                 i_cmd,
    output hjbd_pkg::t_sts                 o_sts,
    input  logic                           i_plug_level,
    input  logic                           i_button_level,
    input  logic                           i_codec_on,
    input  logic [hjbd_pkg::ADC_BITS-1:0]  i_mic_level,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [hjbd_pkg::KIND_BITS-1:0] o_event_kind,
    output logic                           o_mic_flag,
    output logic                           o_amp_enable,
    output logic                           o_jack_inserted,
    output logic                           o_mic_detected,
    output logic                           o_queue_dropped,
    output logic                           o_last
);
    import hjbd_pkg::*;

    localparam logic [TIMER_BITS-1:0] T_ONE = TIMER_BITS'(1);
    localparam logic [TIMER_BITS-1:0] T_ZERO = '0;
    localparam logic [QCW-1:0] Q_FULL = QCW'(QUEUE_DEPTH);
    localparam logic [QCW-1:0] Q_ONE  = QCW'(1);

    // tick inputs
    logic                r_plug, r_button, r_codec;
    logic [ADC_BITS-1:0] r_mic_level;

    // persistent state
    logic r_plug_prev, r_button_prev, r_audio_on, r_inserted, r_mic_on, r_pressed, r_amp_on;
    logic n_plug_prev, n_button_prev, n_audio_on, n_inserted, n_mic_on, n_pressed, n_amp_on;
    logic [TIMER_BITS-1:0] r_ins_t, r_rel_t, r_disp_t, r_amp_t;
    logic [TIMER_BITS-1:0] n_ins_t, n_rel_t, n_disp_t, n_amp_t;
    logic [QCW-1:0] r_qc, n_qc;
    logic r_dropped, n_dropped;

    // per-tick event plan
    logic r_ev_kup, n_ev_kup, r_ev_jack, n_ev_jack;
    logic r_wr_dn, n_wr_dn, r_wr_up, n_wr_up;
    logic [QAW-1:0] r_dn_addr, n_dn_addr, r_up_addr, n_up_addr;
    logic [QCW-1:0] r_disp_n, n_disp_n, r_idx, n_idx;
    t_ev_kind r_jack_kind, n_jack_kind;
    logic r_jack_mic, n_jack_mic;

    // output register
    logic                 r_out_valid, n_out_valid;
    logic [KIND_BITS-1:0] r_out_kind, n_out_kind;
    logic                 r_out_mic, n_out_mic, r_out_last, n_out_last;
    logic                 r_out_amp, r_out_ins, r_out_micp, r_out_drop;

    logic ins_now, fire_i, fire_r, fire_d, fire_a, out_free;
    logic ram_we, ram_wdata, ram_rdata;
    logic [QAW-1:0] ram_waddr;

    assign ins_now  = ~r_plug ^ i_cfg.polarity;
    assign out_free = ~r_out_valid | i_out_ready;

    always_comb begin
        n_plug_prev   = r_plug_prev;
        n_button_prev = r_button_prev;
        n_audio_on    = r_audio_on;
        n_inserted    = r_inserted;
        n_mic_on      = r_mic_on;
        n_pressed     = r_pressed;
        n_amp_on      = r_amp_on;
        n_ins_t       = r_ins_t;
        n_rel_t       = r_rel_t;
        n_disp_t      = r_disp_t;
        n_amp_t       = r_amp_t;
        n_qc          = r_qc;
        n_dropped     = r_dropped;
        n_ev_kup      = r_ev_kup;
        n_ev_jack     = r_ev_jack;
        n_wr_dn       = r_wr_dn;
        n_wr_up       = r_wr_up;
        n_dn_addr     = r_dn_addr;
        n_up_addr     = r_up_addr;
        n_disp_n      = r_disp_n;
        n_jack_kind   = r_jack_kind;
        n_jack_mic    = r_jack_mic;
        n_idx         = r_idx;
        fire_i        = 1'b0;
        fire_r        = 1'b0;
        fire_d        = 1'b0;
        fire_a        = 1'b0;

        if (i_cmd.eval) begin
            n_dropped   = 1'b0;
            n_ev_kup    = 1'b0;
            n_ev_jack   = 1'b0;
            n_wr_dn     = 1'b0;
            n_wr_up     = 1'b0;
            n_disp_n    = '0;
            n_idx       = '0;
            n_jack_kind = EV_INSERT;
            n_jack_mic  = 1'b0;

            if (r_codec != r_audio_on) begin
                n_audio_on = r_codec;
                if (r_codec) begin
                    n_amp_t = load_delay(i_cfg.amp_dly);
                end else begin
                    n_amp_t  = T_ZERO;
                    n_amp_on = 1'b0;
                end
            end

            if (r_plug != r_plug_prev) begin
                n_plug_prev = r_plug;
                n_ins_t     = load_delay(i_cfg.insert_dly);
            end

            if (r_button != r_button_prev) begin
                n_button_prev = r_button;
                n_rel_t       = load_delay(i_cfg.release_to);
                if (!r_pressed) begin
                    n_pressed = 1'b1;
                    if (n_qc < Q_FULL) begin
                        n_wr_dn   = 1'b1;
                        n_dn_addr = n_qc[QAW-1:0];
                        n_qc      = n_qc + Q_ONE;
                    end else begin
                        n_dropped = 1'b1;
                    end
                    n_disp_t = load_delay(i_cfg.dispatch_dly);
                end
            end

            fire_i = (n_ins_t == T_ONE);
            if (n_ins_t != T_ZERO) begin
                n_ins_t = n_ins_t - T_ONE;
            end
            if (fire_i && (ins_now != r_inserted)) begin
                n_ev_jack = 1'b1;
                if (ins_now) begin
                    n_mic_on    = (CMP_BITS'(r_mic_level) >= CMP_BITS'(i_cfg.mic_thr));
                    n_amp_on    = n_audio_on;
                    n_jack_kind = EV_INSERT;
                    n_jack_mic  = n_mic_on;
                end else begin
                    n_jack_mic  = r_mic_on;
                    n_mic_on    = 1'b0;
                    n_amp_on    = 1'b0;
                    n_ev_kup    = n_pressed;
                    n_jack_kind = EV_REMOVE;
                    n_pressed   = 1'b0;
                end
                n_inserted = ins_now;
            end

            fire_r = (n_rel_t == T_ONE);
            if (n_rel_t != T_ZERO) begin
                n_rel_t = n_rel_t - T_ONE;
            end
            if (fire_r && n_pressed) begin
                n_pressed = 1'b0;
                if (n_qc < Q_FULL) begin
                    n_wr_up   = 1'b1;
                    n_up_addr = n_qc[QAW-1:0];
                    n_qc      = n_qc + Q_ONE;
                end else begin
                    n_dropped = 1'b1;
                end
                n_disp_t = load_delay(i_cfg.dispatch_dly);
            end

            fire_d = (n_disp_t == T_ONE);
            if (n_disp_t != T_ZERO) begin
                n_disp_t = n_disp_t - T_ONE;
            end
            if (fire_d) begin
                if (n_inserted && n_mic_on && ins_now) begin
                    n_disp_n = n_qc;
                end
                n_qc = '0;
            end

            fire_a = (n_amp_t == T_ONE);
            if (n_amp_t != T_ZERO) begin
                n_amp_t = n_amp_t - T_ONE;
            end
            if (fire_a) begin
                n_amp_on = n_audio_on & n_inserted;
            end
        end

        if (i_cmd.idx_adv) begin
            n_idx = r_idx + Q_ONE;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_out_kind  = r_out_kind;
        n_out_mic   = r_out_mic;
        n_out_last  = r_out_last;
        if (i_cmd.emit) begin
            n_out_valid = 1'b1;
            n_out_mic   = 1'b0;
            n_out_last  = 1'b0;
            case (i_cmd.emit_src)
                SRC_KUP:  n_out_kind = EV_KUP;
                SRC_JACK: begin
                    n_out_kind = r_jack_kind;
                    n_out_mic  = r_jack_mic;
                end
                SRC_DISP: n_out_kind = ram_rdata ? EV_KDOWN : EV_KUP;
                SRC_STAT: begin
                    n_out_kind = EV_STATUS;
                    n_out_last = 1'b1;
                end
                default:  n_out_kind = EV_STATUS;
            endcase
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    assign ram_we    = (i_cmd.wr_dn & r_wr_dn) | (i_cmd.wr_up & r_wr_up);
    assign ram_waddr = i_cmd.wr_up ? r_up_addr : r_dn_addr;
    assign ram_wdata = i_cmd.wr_dn;

    hjbd_ram #(
        .WIDTH (1),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (n_idx[QAW-1:0]),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plug_prev   <= 1'b0;
            r_button_prev <= 1'b0;
            r_audio_on    <= 1'b0;
            r_inserted    <= 1'b0;
            r_mic_on      <= 1'b0;
            r_pressed     <= 1'b0;
            r_amp_on      <= 1'b0;
            r_ins_t       <= T_ONE;
            r_rel_t       <= T_ZERO;
            r_disp_t      <= T_ZERO;
            r_amp_t       <= T_ZERO;
            r_qc          <= '0;
            r_dropped     <= 1'b0;
            r_ev_kup      <= 1'b0;
            r_ev_jack     <= 1'b0;
            r_wr_dn       <= 1'b0;
            r_wr_up       <= 1'b0;
            r_disp_n      <= '0;
            r_idx         <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_plug_prev   <= n_plug_prev;
            r_button_prev <= n_button_prev;
            r_audio_on    <= n_audio_on;
            r_inserted    <= n_inserted;
            r_mic_on      <= n_mic_on;
            r_pressed     <= n_pressed;
            r_amp_on      <= n_amp_on;
            r_ins_t       <= n_ins_t;
            r_rel_t       <= n_rel_t;
            r_disp_t      <= n_disp_t;
            r_amp_t       <= n_amp_t;
            r_qc          <= n_qc;
            r_dropped     <= n_dropped;
            r_ev_kup      <= n_ev_kup;
            r_ev_jack     <= n_ev_jack;
            r_wr_dn       <= n_wr_dn;
            r_wr_up       <= n_wr_up;
            r_disp_n      <= n_disp_n;
            r_idx         <= n_idx;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_plug      <= i_plug_level;
            r_button    <= i_button_level;
            r_codec     <= i_codec_on;
            r_mic_level <= i_mic_level;
        end
        r_dn_addr   <= n_dn_addr;
        r_up_addr   <= n_up_addr;
        r_jack_kind <= n_jack_kind;
        r_jack_mic  <= n_jack_mic;
        r_out_kind  <= n_out_kind;
        r_out_mic   <= n_out_mic;
        r_out_last  <= n_out_last;
        if (i_cmd.emit) begin
            r_out_amp  <= r_amp_on;
            r_out_ins  <= r_inserted;
            r_out_micp <= r_mic_on;
            r_out_drop <= r_dropped;
        end
    end

    assign o_sts.ev_kup    = r_ev_kup;
    assign o_sts.ev_jack   = r_ev_jack;
    assign o_sts.disp_any  = (r_disp_n != '0);
    assign o_sts.disp_last = ((r_idx + Q_ONE) == r_disp_n);
    assign o_sts.out_free  = out_free;

    assign o_out_valid     = r_out_valid;
    assign o_event_kind    = r_out_kind;
    assign o_mic_flag      = r_out_mic;
    assign o_amp_enable    = r_out_amp;
    assign o_jack_inserted = r_out_ins;
    assign o_mic_detected  = r_out_micp;
    assign o_queue_dropped = r_out_drop;
    assign o_last          = r_out_last;
endmodule

// ===== rtl/headset_jack_button_detector_unit.sv =====
// Top level of the headset jack and answer-button detector.
//
//  channel   dir   handshake      payload
//  i_item    in    valid/ready    plug_level, button_level, codec_on, mic_level
//  o_evt     out   valid/ready    event_kind, mic_flag, amp_enable, jack_inserted,
//                                 mic_detected, queue_dropped, last
//  apb       in    psel/penable   paddr, pwdata, prdata (register i at 4*i)
//
// A tick is accepted, evaluated and given its queue writes, then its results are emitted in
// order (key up, jack event, each dispatched key event, closing status).
// Dispatch reads the key event queue RAM one entry per cycle while the output is free.
// The next tick is taken once the status transaction is loaded into the output register.
// Synchronous active-low reset; output stalls hold the sequencer in its emit state.
module headset_jack_button_detector_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    hjbd_in_if.sink                     i_item,
    hjbd_out_if.source                  o_evt,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [hjbd_pkg::APB_AW-1:0] paddr,
    input  logic [hjbd_pkg::APB_DW-1:0] pwdata,
    output logic [hjbd_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);
    import hjbd_pkg::*;

    t_cfg cfg;
    t_cmd cmd;
    t_sts sts;
    logic in_ready;

    assign i_item.ready = in_ready;

    hjbd_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    hjbd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    hjbd_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_plug_level    (i_item.plug_level),
        .i_button_level  (i_item.button_level),
        .i_codec_on      (i_item.codec_on),
        .i_mic_level     (i_item.mic_level),
        .o_out_valid     (o_evt.valid),
        .i_out_ready     (o_evt.ready),
        .o_event_kind    (o_evt.event_kind),
        .o_mic_flag      (o_evt.mic_flag),
        .o_amp_enable    (o_evt.amp_enable),
        .o_jack_inserted (o_evt.jack_inserted),
        .o_mic_detected  (o_evt.mic_detected),
        .o_queue_dropped (o_evt.queue_dropped),
        .o_last          (o_evt.last)
    );
endmodule

// ===== rtl/hjbd_chk.sv =====
// Port-level checker for the detector output channel, bound to the top level.
module hjbd_chk (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic [hjbd_pkg::KIND_BITS-1:0] i_event_kind,
    input logic                           i_mic_flag,
    input logic                           i_jack_inserted,
    input logic                           i_mic_detected,
    input logic                           i_last
);
    import hjbd_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output transaction dropped while stalled");

    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((i_event_kind == EV_STATUS) == i_last))
        else $error("last flag not on the status transaction alone");

    a_mic_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_mic_flag |-> (i_event_kind == EV_INSERT || i_event_kind == EV_REMOVE))
        else $error("mic flag set on a non-jack transaction");

    a_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_event_kind == EV_INSERT) |-> i_jack_inserted &&
            (i_mic_flag == i_mic_detected))
        else $error("insert transaction disagrees with jack state");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");
endmodule

bind headset_jack_button_detector_unit hjbd_chk u_hjbd_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_evt.valid),
    .i_out_ready     (o_evt.ready),
    .i_event_kind    (o_evt.event_kind),
    .i_mic_flag      (o_evt.mic_flag),
    .i_jack_inserted (o_evt.jack_inserted),
    .i_mic_detected  (o_evt.mic_detected),
    .i_last          (o_evt.last)
);

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the headset jack and answer-button detector.
module testbench;
    import hjbd_pkg::*;

    localparam int         SETTLE_CYCLES = 40;
    localparam int         STALL_LIMIT   = 4000;
    localparam int         SHOW_LIMIT    = 10;
    localparam int         ADC_MAX       = (1 << ADC_BITS) - 1;
    localparam logic [2:0] REG_UNUSED    = 3'd6;

    typedef struct packed {
        t_ev_kind kind;
        logic     mic;
        logic     amp;
        logic     jack;
        logic     mic_on;
        logic     dropped;
        logic     last;
    } evt_t;

    typedef struct packed {
        logic                plug;
        logic                button;
        logic                codec;
        logic [ADC_BITS-1:0] adc;
    } tick_t;

    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [APB_AW-1:0] paddr   = '0;
    logic [APB_DW-1:0] pwdata  = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    hjbd_in_if  tick_ch();
    hjbd_out_if evt_ch();

    headset_jack_button_detector_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (tick_ch),
        .o_evt   (evt_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #1 i_clk = ~i_clk;

    // detector mirror: configuration
    logic                cfg_polarity;
    logic [DLY_BITS-1:0] cfg_insert_dly;
    logic [DLY_BITS-1:0] cfg_release_to;
    logic [DLY_BITS-1:0] cfg_dispatch_dly;
    logic [DLY_BITS-1:0] cfg_amp_dly;
    logic [THR_BITS-1:0] cfg_mic_thr;

    // detector mirror: state
    logic                  plug_seen;
    logic                  button_seen;
    logic                  codec_seen;
    logic                  jack_in;
    logic                  mic_det;
    logic                  key_held;
    logic                  amp_live;
    logic [TIMER_BITS-1:0] t_insert;
    logic [TIMER_BITS-1:0] t_release;
    logic [TIMER_BITS-1:0] t_dispatch;
    logic [TIMER_BITS-1:0] t_amp;
    logic                  key_log [QUEUE_DEPTH];
    int                    key_count;

    evt_t pending_events[$];
    evt_t evt_seen;
    evt_t evt_want;
    int   error_count   = 0;
    int   send_idle_pct = 0;
    int   stall_pct     = 0;
    int   quiet_cycles  = 0;

    function automatic logic [TIMER_BITS-1:0] clamp_delay(input logic [DLY_BITS-1:0] d);
        longint v;
        v = (d == '0) ? 1 : longint'(d);
        if (v > (longint'(1) << TIMER_BITS) - 1) begin
            v = (longint'(1) << TIMER_BITS) - 1;
        end
        return TIMER_BITS'(v);
    endfunction

    function automatic logic push_key(input logic down);
        if (key_count >= QUEUE_DEPTH) begin
            return 1'b0;
        end
        key_log[key_count] = down;
        key_count++;
        return 1'b1;
    endfunction

    function automatic string evt_text(input evt_t e);
        return $sformatf("kind=%0d mic=%b amp=%b jack=%b mic_on=%b drop=%b last=%b",
                         e.kind, e.mic, e.amp, e.jack, e.mic_on, e.dropped, e.last);
    endfunction

    task automatic note_failure(input string msg);
        error_count++;
        if (error_count <= SHOW_LIMIT) begin
            $display("%s", msg);
        end
    endtask

    task automatic count_down(inout logic [TIMER_BITS-1:0] t, output logic fired);
        fired = (t == TIMER_BITS'(1));
        if (t != '0) begin
            t = t - TIMER_BITS'(1);
        end
    endtask

    task automatic reset_mirror();
        cfg_polarity     = RST_POLARITY;
        cfg_insert_dly   = RST_INSERT_DLY;
        cfg_release_to   = RST_RELEASE_TO;
        cfg_dispatch_dly = RST_DISPATCH_DLY;
        cfg_amp_dly      = RST_AMP_DLY;
        cfg_mic_thr      = RST_MIC_THR;
        plug_seen   = 1'b0;
        button_seen = 1'b0;
        codec_seen  = 1'b0;
        jack_in     = 1'b0;
        mic_det     = 1'b0;
        key_held    = 1'b0;
        amp_live    = 1'b0;
        t_insert    = TIMER_BITS'(1);
        t_release   = '0;
        t_dispatch  = '0;
        t_amp       = '0;
        key_count   = 0;
    endtask

    task automatic predict_tick_events(input tick_t t);
        evt_t evs[$];
        evt_t e;
        logic ins_now;
        logic dropped;
        logic fired;
        logic had_mic;
        ins_now = ~t.plug ^ cfg_polarity;
        dropped = 1'b0;
        e       = '0;

        if (t.codec != codec_seen) begin
            codec_seen = t.codec;
            if (t.codec) begin
                t_amp = clamp_delay(cfg_amp_dly);
            end else begin
                t_amp    = '0;
                amp_live = 1'b0;
            end
        end

        if (t.plug != plug_seen) begin
            plug_seen = t.plug;
            t_insert  = clamp_delay(cfg_insert_dly);
        end

        if (t.button != button_seen) begin
            button_seen = t.button;
            t_release   = clamp_delay(cfg_release_to);
            if (!key_held) begin
                key_held = 1'b1;
                if (!push_key(1'b1)) begin
                    dropped = 1'b1;
                end
                t_dispatch = clamp_delay(cfg_dispatch_dly);
            end
        end

        count_down(t_insert, fired);
        if (fired && ins_now != jack_in) begin
            if (ins_now) begin
                mic_det  = (t.adc >= cfg_mic_thr);
                amp_live = codec_seen;
                e.kind   = EV_INSERT;
                e.mic    = mic_det;
                evs.push_back(e);
            end else begin
                had_mic  = mic_det;
                mic_det  = 1'b0;
                amp_live = 1'b0;
                if (key_held) begin
                    e.kind = EV_KUP;
                    e.mic  = 1'b0;
                    evs.push_back(e);
                end
                e.kind   = EV_REMOVE;
                e.mic    = had_mic;
                evs.push_back(e);
                key_held = 1'b0;
            end
            jack_in = ins_now;
        end

        count_down(t_release, fired);
        if (fired && key_held) begin
            key_held = 1'b0;
            if (!push_key(1'b0)) begin
                dropped = 1'b1;
            end
            t_dispatch = clamp_delay(cfg_dispatch_dly);
        end

        count_down(t_dispatch, fired);
        if (fired) begin
            if (jack_in && mic_det && ins_now) begin
                for (int i = 0; i < key_count; i++) begin
                    e.kind = key_log[i] ? EV_KDOWN : EV_KUP;
                    e.mic  = 1'b0;
                    evs.push_back(e);
                end
            end
            key_count = 0;
        end

        count_down(t_amp, fired);
        if (fired) begin
            amp_live = codec_seen & jack_in;
        end

        e.kind = EV_STATUS;
        e.mic  = 1'b0;
        evs.push_back(e);

        for (int k = 0; k < evs.size(); k++) begin
            e         = evs[k];
            e.amp     = amp_live;
            e.jack    = jack_in;
            e.mic_on  = mic_det;
            e.dropped = dropped;
            e.last    = (k == evs.size() - 1);
            pending_events.push_back(e);
        end
    endtask

    task automatic apb_xfer(input logic wr, input logic [2:0] idx,
                            input logic [APB_DW-1:0] wdata, output logic [APB_DW-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        rdata = prdata;
        @(negedge i_clk);
    endtask

    task automatic check_reg(input logic [2:0] idx);
        logic [APB_DW-1:0] got;
        logic [APB_DW-1:0] want;
        apb_xfer(1'b0, idx, '0, got);
        case (idx)
            REG_POLARITY:     want = APB_DW'(cfg_polarity);
            REG_INSERT_DLY:   want = APB_DW'(cfg_insert_dly);
            REG_RELEASE_TO:   want = APB_DW'(cfg_release_to);
            REG_DISPATCH_DLY: want = APB_DW'(cfg_dispatch_dly);
            REG_AMP_DLY:      want = APB_DW'(cfg_amp_dly);
            REG_MIC_THR:      want = APB_DW'(cfg_mic_thr);
            default:          want = '0;
        endcase
        if (got !== want) begin
            note_failure($sformatf("register %0d readback: expected %h, got %h",
                                   idx, want, got));
        end
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [APB_DW-1:0] value);
        logic [APB_DW-1:0] unused_rd;
        apb_xfer(1'b1, idx, value, unused_rd);
        case (idx)
            REG_POLARITY:     cfg_polarity     = value[0];
            REG_INSERT_DLY:   cfg_insert_dly   = value[DLY_BITS-1:0];
            REG_RELEASE_TO:   cfg_release_to   = value[DLY_BITS-1:0];
            REG_DISPATCH_DLY: cfg_dispatch_dly = value[DLY_BITS-1:0];
            REG_AMP_DLY:      cfg_amp_dly      = value[DLY_BITS-1:0];
            REG_MIC_THR:      cfg_mic_thr      = value[THR_BITS-1:0];
            default: ;
        endcase
        if (idx <= REG_MIC_THR) begin
            check_reg(idx);
        end
    endtask

    task automatic configure(input logic pol,
                             input logic [DLY_BITS-1:0] ins_d, rel_d, disp_d, amp_d,
                             input logic [THR_BITS-1:0] thr);
        write_reg(REG_UNUSED, $urandom());
        write_reg(REG_POLARITY, APB_DW'(pol));
        write_reg(REG_INSERT_DLY, APB_DW'(ins_d));
        write_reg(REG_RELEASE_TO, APB_DW'(rel_d));
        write_reg(REG_DISPATCH_DLY, APB_DW'(disp_d));
        write_reg(REG_AMP_DLY, APB_DW'(amp_d));
        write_reg(REG_MIC_THR, APB_DW'(thr));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic send_tick(input logic plug, input logic button, input logic codec,
                             input logic [ADC_BITS-1:0] adc);
        tick_t t;
        t = {plug, button, codec, adc};
        if ($urandom_range(99) < send_idle_pct) begin
            tick_ch.valid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        tick_ch.valid        <= 1'b1;
        tick_ch.plug_level   <= plug;
        tick_ch.button_level <= button;
        tick_ch.codec_on     <= codec;
        tick_ch.mic_level    <= adc;
        do @(posedge i_clk); while (tick_ch.ready !== 1'b1);
        predict_tick_events(t);
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        tick_ch.valid <= 1'b0;
        while (pending_events.size() != 0) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        stall_pct     = recv_pct;
    endtask

    task automatic test_power_on_check();
        set_idling(0, 0);
        for (int r = REG_POLARITY; r <= REG_MIC_THR; r++) begin
            check_reg(3'(r));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        send_tick(1'b0, 1'b0, 1'b1, 10'd256);
        send_tick(1'b0, 1'b0, 1'b1, 10'd0);
        wait_idle();
    endtask

    task automatic test_jack_and_codec();
        configure(1'b0, 16'd0, 16'd1, 16'd2, 16'd1, 10'd1023);
        send_tick(1'b1, 1'b0, 1'b1, 10'd500);
        send_tick(1'b0, 1'b0, 1'b1, 10'd1022);
        send_tick(1'b1, 1'b0, 1'b1, 10'd0);
        send_tick(1'b0, 1'b0, 1'b1, 10'd1023);
        send_tick(1'b0, 1'b0, 1'b0, 10'd77);
        send_tick(1'b0, 1'b0, 1'b1, 10'd300);
        wait_idle();
    endtask

    task automatic test_key_dispatch();
        configure(1'b0, 16'd1, 16'd3, 16'd2, 16'd1, 10'd1023);
        send_tick(1'b0, 1'b1, 1'b1, 10'd0);
        send_tick(1'b0, 1'b1, 1'b1, 10'd0);
        send_tick(1'b0, 1'b0, 1'b1, 10'd0);
        // pull the jack with the button still held
        send_tick(1'b1, 1'b0, 1'b1, 10'd0);
        send_tick(1'b1, 1'b0, 1'b1, 10'd0);
        send_tick(1'b0, 1'b0, 1'b1, 10'd1023);
        wait_idle();
    endtask

    task automatic test_queue_overflow();
        configure(1'b0, 16'd1, 16'd0, 16'd2, 16'd1, 10'd1023);
        for (int n = 0; n < QUEUE_DEPTH / 2 + 1; n++) begin
            send_tick(1'b0, ~n[0], 1'b1, 10'd0);
        end
        send_tick(1'b0, 1'b1, 1'b1, 10'd0);
        wait_idle();
    endtask

    task automatic test_polarity_no_mic();
        configure(1'b1, 16'd1, 16'd0, 16'd1, 16'd1, 10'd1023);
        send_tick(1'b1, 1'b1, 1'b1, 10'd0);
        send_tick(1'b0, 1'b1, 1'b1, 10'd0);
        send_tick(1'b1, 1'b1, 1'b1, 10'd0);
        send_tick(1'b1, 1'b0, 1'b1, 10'd0);
        wait_idle();
    endtask

    task automatic test_random_traffic();
        logic                plug;
        logic                button;
        logic                codec;
        logic                toggle;
        logic [THR_BITS-1:0] thr;
        int                  adc;
        int                  ticks;
        plug   = plug_seen;
        button = button_seen;
        codec  = codec_seen;
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                1:       set_idling(54, 0);
                2:       set_idling(0, 54);
                3, 4:    set_idling(10, 10);
                default: set_idling(0, 0);
            endcase
            case ($urandom_range(3))
                0:       thr = '0;
                1:       thr = '1;
                default: thr = THR_BITS'($urandom_range(ADC_MAX));
            endcase
            if (phase == 4) begin
                configure(1'b1, '1, '1, '1, '1, '1);
            end else if (phase == 5) begin
                configure(1'($urandom_range(1)), 16'd1, 16'd0, 16'd3,
                          DLY_BITS'($urandom_range(4)), '0);
            end else begin
                configure(1'($urandom_range(1)), DLY_BITS'($urandom_range(6)),
                          DLY_BITS'($urandom_range(6)), DLY_BITS'($urandom_range(12)),
                          DLY_BITS'($urandom_range(6)), thr);
            end
            ticks = (phase == 4) ? 10 : 26;
            for (int n = 0; n < ticks; n++) begin
                if ($urandom_range(99) < ((phase == 5) ? 3 : 8)) begin
                    plug = ~plug;
                end
                // bursts of button edges fill the key queue in the last phase
                toggle = (phase == 5) ? (n % 16 < 10) : ($urandom_range(99) < 35);
                if (toggle) begin
                    button = ~button;
                end
                if ($urandom_range(99) < 6) begin
                    codec = ~codec;
                end
                case ($urandom_range(3))
                    1: begin
                        adc = int'(cfg_mic_thr) + int'($urandom_range(2)) - 1;
                        if (adc < 0) adc = 0;
                        if (adc > ADC_MAX) adc = ADC_MAX;
                    end
                    2:       adc = $urandom_range(1) ? ADC_MAX : 0;
                    default: adc = $urandom_range(ADC_MAX);
                endcase
                send_tick(plug, button, codec, ADC_BITS'(adc));
            end
            wait_idle();
        end
    endtask

    always @(negedge i_clk) begin
        evt_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && evt_ch.valid === 1'b1 && evt_ch.ready === 1'b1) begin
            evt_seen = {evt_ch.event_kind, evt_ch.mic_flag, evt_ch.amp_enable,
                        evt_ch.jack_inserted, evt_ch.mic_detected, evt_ch.queue_dropped,
                        evt_ch.last};
            if (pending_events.size() == 0) begin
                note_failure({"unexpected event: ", evt_text(evt_seen)});
            end else begin
                evt_want = pending_events.pop_front();
                if (evt_seen !== evt_want) begin
                    note_failure({"event mismatch: expected ", evt_text(evt_want),
                                  " got ", evt_text(evt_seen)});
                end
            end
        end
    end

    initial begin
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((tick_ch.valid && tick_ch.ready) || (evt_ch.valid && evt_ch.ready)
                    || (psel && penable && pready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        tick_ch.valid        = 1'b0;
        tick_ch.plug_level   = 1'b0;
        tick_ch.button_level = 1'b0;
        tick_ch.codec_on     = 1'b0;
        tick_ch.mic_level    = '0;
        evt_ch.ready         = 1'b0;
        reset_mirror();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_power_on_check();
        test_jack_and_codec();
        test_key_dispatch();
        test_queue_overflow();
        test_polarity_no_mic();
        test_random_traffic();
        wait_idle();
        if (error_count == 0 && pending_events.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== headset_jack_button_detector_unit.f =====
rtl/hjbd_pkg.sv
rtl/hjbd_if.sv
rtl/hjbd_ram.sv
rtl/hjbd_regs.sv
rtl/hjbd_ctrl.sv
rtl/hjbd_dp.sv
rtl/headset_jack_button_detector_unit.sv
rtl/hjbd_chk.sv
bench/testbench.sv
